### rtl/rgwc_pkg.sv
`timescale 1ns / 1ps
package rgwc_pkg;
   localparam int WinW = 28;
   localparam int RttW = 16;
   localparam int GradW = 25;
   localparam logic [WinW-1:0] WinMax = {WinW{1'b1}};
   localparam logic [RttW-1:0] LastRttReset = 16'd50;
   localparam logic [WinW-1:0] WinReset = 28'd3276800;

   localparam logic [2:0] CSR_EWMA_GAIN = 3'd0;
   localparam logic [2:0] CSR_DECREASE  = 3'd1;
   localparam logic [2:0] CSR_ADD_STEP  = 3'd2;
   localparam logic [2:0] CSR_LOW_THR   = 3'd3;
   localparam logic [2:0] CSR_HIGH_THR  = 3'd4;
   localparam logic [2:0] CSR_BASE_RTT  = 3'd5;
   localparam logic [2:0] CSR_MIN_WIN   = 3'd6;
   localparam logic [2:0] CSR_INC_COUNT = 3'd7;

   localparam logic [1:0] REGION_LOW_ADD   = 2'd0;
   localparam logic [1:0] REGION_HIGH_DEC  = 2'd1;
   localparam logic [1:0] REGION_GRAD_ADD  = 2'd2;
   localparam logic [1:0] REGION_GRAD_DEC  = 2'd3;

   typedef struct packed {
      logic load;     // capture beat, compute rtt
      logic grad;     // ewma product step
      logic grad_fin; // ewma round and classify
      logic mul1;     // w*beta
      logic mul2;     // *factor, set up divide
      logic div_step;
      logic finish;   // apply and clamp window
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_div;
   } sts_type;
endpackage

### rtl/rgwc_datapath.sv
`timescale 1ns / 1ps
module rgwc_datapath import rgwc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output sts_type         sts,
   input  logic [31:0]     arrive,
   input  logic [31:0]     sent,
   input  logic [8:0]      cfg_gain,
   input  logic [8:0]      cfg_beta,
   input  logic [20:0]     cfg_step,
   input  logic [15:0]     cfg_low,
   input  logic [15:0]     cfg_high,
   input  logic [15:0]     cfg_base,
   input  logic [27:0]     cfg_minw,
   input  logic [7:0]      cfg_count,
   output logic [WinW-1:0] win_out,
   output logic [RttW-1:0] rtt_out,
   output logic [1:0]      region_out
);
   logic [RttW-1:0] last_rtt_ff, last_rtt_in, rtt_ff, rtt_in;
   logic signed [GradW-1:0] grad_ff, grad_in;
   logic [WinW-1:0] win_ff, win_in;
   logic [1:0] region_ff, region_in;
   logic signed [45:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [39:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [8:0] a, beta;
   logic [31:0] raw;
   logic signed [18:0] diff;
   logic signed [46:0] rnd;
   logic signed [46:0] g_full;
   logic signed [GradW-1:0] g_sat;
   logic [64:0] trial;
   logic [29:0] w_add;
   logic [WinW:0] w_sub;
   logic [29:0] w_fin;

   assign a    = (cfg_gain > 9'd256) ? 9'd256 : cfg_gain;
   assign beta = (cfg_beta > 9'd256) ? 9'd256 : cfg_beta;
   assign raw  = arrive - sent;
   assign diff = $signed({3'b0, rtt_ff}) - $signed({3'b0, last_rtt_ff});
   assign rnd  = {acc_ff[45], acc_ff} + 47'sd128;
   assign g_full = rnd >>> 8;
   always_comb begin
      if (g_full > 47'sd16777215) g_sat = 25'sd16777215;
      else if (g_full < -47'sd16777216) g_sat = -25'sd16777216;
      else g_sat = g_full[GradW-1:0];
   end
   assign trial = {rem_ff, quo_ff[63]} - {25'b0, den_ff};
   assign sts.div_done = (cnt_ff == 7'd0);
   assign sts.need_div = region_ff[0];

   always_comb begin
      last_rtt_in = last_rtt_ff; rtt_in = rtt_ff; grad_in = grad_ff;
      win_in = win_ff; region_in = region_ff; acc_in = acc_ff;
      prod_in = prod_ff; rem_in = rem_ff; quo_in = quo_ff;
      den_in = den_ff; cnt_in = cnt_ff;
      w_add = '0; w_sub = '0; w_fin = '0;
      if (cmd.load) rtt_in = (raw > 32'd65535) ? 16'hFFFF : raw[15:0];
      if (cmd.grad)
         acc_in = $signed({1'b0, 9'd256 - a}) * grad_ff
                + $signed({1'b0, a}) * diff * 46'sd256;
      if (cmd.grad_fin) begin
         grad_in = g_sat;
         last_rtt_in = rtt_ff;
         if (rtt_ff < cfg_low) region_in = REGION_LOW_ADD;
         else if (rtt_ff > cfg_high) region_in = REGION_HIGH_DEC;
         else if (g_sat <= 0) region_in = REGION_GRAD_ADD;
         else region_in = REGION_GRAD_DEC;
      end
      if (cmd.mul1) prod_in = {27'b0, 37'(win_ff) * 37'(beta)};
      if (cmd.mul2) begin
         if (region_ff == REGION_HIGH_DEC) begin
            prod_in = prod_ff[36:0] * (rtt_ff - cfg_high);
            den_in = {16'b0, rtt_ff, 8'b0};
         end else begin
            prod_in = prod_ff[36:0] * grad_ff[23:0];
            den_in = {8'b0, (cfg_base == 16'd0) ? 16'd1 : cfg_base, 16'b0};
         end
         quo_in = prod_in; rem_in = '0; cnt_in = 7'd64;
      end
      if (cmd.div_step) begin
         // restoring divide, one quotient bit per div_step command
         if (!trial[64]) begin
            rem_in = trial[63:0]; quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
      if (cmd.finish) begin
         case (region_ff)
            REGION_LOW_ADD:  w_add = {2'b0, win_ff} + {9'b0, cfg_step};
            REGION_GRAD_ADD: w_add = {2'b0, win_ff} + cfg_count * cfg_step;
            default: begin
               w_sub = {1'b0, win_ff} - quo_ff[WinW:0];
               w_add = (quo_ff > {36'b0, win_ff}) ? 30'd0 : {1'b0, w_sub};
            end
         endcase
         w_fin = (w_add > {2'b0, WinMax}) ? {2'b0, WinMax} : w_add;
         win_in = (w_fin[WinW-1:0] < cfg_minw) ? cfg_minw : w_fin[WinW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; prod_ff <= prod_in; rem_ff <= rem_in; quo_ff <= quo_in;
      den_ff <= den_in; rtt_ff <= rtt_in; region_ff <= region_in;
      if (reset) begin
         last_rtt_ff <= LastRttReset; grad_ff <= '0; win_ff <= WinReset;
         cnt_ff <= '0;
      end else begin
         last_rtt_ff <= last_rtt_in; grad_ff <= grad_in; win_ff <= win_in;
         cnt_ff <= cnt_in;
      end
   end
   assign win_out = win_ff;
   assign rtt_out = rtt_ff;
   assign region_out = region_ff;
endmodule

### rtl/rgwc_control.sv
`timescale 1ns / 1ps
module rgwc_control import rgwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_GRAD = 3'd1, S_GFIN = 3'd2,
      S_MUL1 = 3'd3, S_MUL2 = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
   logic [2:0] state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_in = S_GRAD; end
         S_GRAD: begin cmd.grad = 1'b1; state_in = S_GFIN; end
         S_GFIN: begin cmd.grad_fin = 1'b1; state_in = S_MUL1; end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = sts.need_div ? S_MUL2 : S_FIN;
         end
         S_MUL2: begin cmd.mul2 = 1'b1; state_in = S_DIV; end
         S_DIV: begin
            if (sts.div_done) state_in = S_FIN;
            else cmd.div_step = 1'b1;
         end
         S_FIN: begin cmd.finish = 1'b1; state_in = S_OUT; end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

### rtl/rtt_gradient_window_control_core.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)
// req_    | in  | ack_arrival_ms[31:0], data_send_ms[63:32]
// rsp_    | out | window[27:0], rtt_ms[43:28], region[45:44], zero pad to 48
// csr_    | in  | index 0..7, data 28 bits
// Each beat runs load, gradient, round and classify, w*beta, then in divide regions
// the 64-step restoring divider, then finish and the wait for rsp_tready.
// Reset is synchronous; one beat is in flight, req_tready is low until the
// result beat has been taken.
module rtt_gradient_window_control_core import rgwc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // ack_arrival_ms, data_send_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // window, rtt_ms, region
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   logic [8:0] gain_ff, beta_ff;
   logic [20:0] step_ff;
   logic [15:0] low_ff, high_ff, base_ff;
   logic [27:0] minw_ff;
   logic [7:0] count_ff;
   logic [WinW-1:0] win;
   logic [RttW-1:0] rtt;
   logic [1:0] region;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 9'd205; beta_ff <= 9'd77; step_ff <= 21'd16384;
         low_ff <= 16'd60; high_ff <= 16'd150; base_ff <= 16'd50;
         minw_ff <= 28'd65536; count_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EWMA_GAIN: gain_ff <= csr_wdata[8:0];
            CSR_DECREASE:  beta_ff <= csr_wdata[8:0];
            CSR_ADD_STEP:  step_ff <= csr_wdata[20:0];
            CSR_LOW_THR:   low_ff <= csr_wdata[15:0];
            CSR_HIGH_THR:  high_ff <= csr_wdata[15:0];
            CSR_BASE_RTT:  base_ff <= csr_wdata[15:0];
            CSR_MIN_WIN:   minw_ff <= csr_wdata;
            CSR_INC_COUNT: count_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   rgwc_control u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd), .sts(sts)
   );
   rgwc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .arrive(req_tdata[31:0]), .sent(req_tdata[63:32]),
      .cfg_gain(gain_ff), .cfg_beta(beta_ff), .cfg_step(step_ff),
      .cfg_low(low_ff), .cfg_high(high_ff), .cfg_base(base_ff),
      .cfg_minw(minw_ff), .cfg_count(count_ff),
      .win_out(win), .rtt_out(rtt), .region_out(region)
   );
   assign rsp_tdata = {2'b0, region, rtt, win};
endmodule

### rtl/rgwc_checker.sv
`timescale 1ns / 1ps
module rgwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept with pending result");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("result too early");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:46] == 2'b00) else $error("pad bits set");
endmodule

bind rtt_gradient_window_control_core rgwc_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench import rgwc_pkg::*;;

   typedef struct packed {
      logic [31:0] send_ms;
      logic [31:0] arrive_ms;
   } ack_beat_type;

   typedef struct packed {
      logic [1:0]  region;
      logic [15:0] rtt_ms;
      logic [27:0] window;
   } window_update_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [27:0] csr_wdata = '0;

   rtt_gradient_window_control_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the control registers and the controller state
   logic [8:0]  gain_q;
   logic [8:0]  beta_q;
   logic [20:0] step_q;
   logic [15:0] low_thr_q;
   logic [15:0] high_thr_q;
   logic [15:0] base_rtt_q;
   logic [27:0] min_win_q;
   logic [7:0]  inc_count_q;
   logic [15:0] last_rtt_q;
   logic signed [24:0] gradient;
   logic [27:0] cwnd;

   ack_beat_type      ack_queue[$];
   window_update_type update_queue[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off = 0;
   bit  hold_done = 1'b0;
   int  mismatches = 0;
   int  updates_seen = 0;
   int  cycles = 0;
   int  region_hits[4] = '{0, 0, 0, 0};

   function automatic window_update_type predict_window(ack_beat_type ack);
      window_update_type upd;
      logic [31:0] raw;
      logic [63:0] alpha, beta, base, w, dec;
      logic signed [63:0] diff, acc;
      logic [15:0] rtt;
      raw = ack.arrive_ms - ack.send_ms;
      rtt = raw > 32'hFFFF ? 16'hFFFF : raw[15:0];
      alpha = gain_q > 9'd256 ? 64'd256 : 64'(gain_q);
      beta = beta_q > 9'd256 ? 64'd256 : 64'(beta_q);
      base = base_rtt_q == 16'd0 ? 64'd1 : 64'(base_rtt_q);
      diff = $signed(64'(rtt)) - $signed(64'(last_rtt_q));
      acc = $signed(64'd256 - alpha) * 64'(gradient) + $signed(alpha) * diff * 256 + 128;
      acc = acc >>> 8;
      if (acc > 64'sd16777215) acc = 64'sd16777215;
      if (acc < -64'sd16777216) acc = -64'sd16777216;
      gradient = acc[24:0];
      last_rtt_q = rtt;
      w = 64'(cwnd);
      if (rtt < low_thr_q) begin
         upd.region = REGION_LOW_ADD;
         w = w + 64'(step_q);
      end else if (rtt > high_thr_q) begin
         upd.region = REGION_HIGH_DEC;
         dec = (w * beta * 64'(rtt - high_thr_q)) / (64'd256 * 64'(rtt));
         w = dec > w ? 64'd0 : w - dec;
      end else if (gradient <= 0) begin
         upd.region = REGION_GRAD_ADD;
         w = w + 64'(inc_count_q) * 64'(step_q);
      end else begin
         upd.region = REGION_GRAD_DEC;
         dec = (w * beta * 64'(gradient)) / (64'd65536 * base);
         w = dec > w ? 64'd0 : w - dec;
      end
      if (w > 64'(WinMax)) w = 64'(WinMax);
      if (w < 64'(min_win_q)) w = 64'(min_win_q);
      cwnd = w[27:0];
      upd.window = cwnd;
      upd.rtt_ms = rtt;
      return upd;
   endfunction

   // driver: offer beats from the queue, predict on acceptance
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            update_queue.push_back(predict_window(ack_queue.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (ack_queue.size() > (req_tvalid && req_tready ? 0 : 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= ack_queue[0];
            end else begin
               req_tvalid <= 1'b0;
               req_tdata <= {$urandom, $urandom};
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            window_update_type got, want;
            got = rsp_tdata[45:0];
            updates_seen <= updates_seen + 1;
            if (update_queue.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result beat %h", rsp_tdata);
            end else begin
               want = update_queue.pop_front();
               region_hits[want.region] = region_hits[want.region] + 1;
               if (got !== want || rsp_tdata[47:46] !== 2'b00) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch: window %h/%h rtt %0d/%0d region %0d/%0d",
                              want.window, got.window, want.rtt_ms, got.rtt_ms,
                              want.region, got.region);
               end
            end
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   // long receiver hold-off, counted in its own process, while the sender
   // still has beats queued
   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
      else if (!hold_done && updates_seen == 400) begin
         hold_off <= 3000;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycles > 900000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [27:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_EWMA_GAIN: gain_q = val[8:0];
         CSR_DECREASE:  beta_q = val[8:0];
         CSR_ADD_STEP:  step_q = val[20:0];
         CSR_LOW_THR:   low_thr_q = val[15:0];
         CSR_HIGH_THR:  high_thr_q = val[15:0];
         CSR_BASE_RTT:  base_rtt_q = val[15:0];
         CSR_MIN_WIN:   min_win_q = val[27:0];
         CSR_INC_COUNT: inc_count_q = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain_updates();
      while (ack_queue.size() != 0 || update_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic queue_ack(input logic [31:0] arrive, input logic [31:0] rtt);
      ack_beat_type a;
      a.arrive_ms = arrive;
      a.send_ms = arrive - rtt;
      ack_queue.push_back(a);
   endtask

   // rtt mostly near the thresholds, sometimes huge or wrapped
   task automatic queue_random_acks(input int n, input int hi_thr);
      logic [31:0] rtt;
      repeat (n) begin
         case ($urandom_range(9))
            0: rtt = $urandom;
            1: rtt = $urandom_range(65535);
            default: rtt = $urandom_range(hi_thr + hi_thr / 2 + 4);
         endcase
         queue_ack($urandom, rtt);
      end
   endtask

   task automatic randomize_csrs();
      write_csr(CSR_EWMA_GAIN, 28'($urandom_range(511)));
      write_csr(CSR_DECREASE, 28'($urandom_range(511)));
      write_csr(CSR_ADD_STEP, 28'($urandom_range(21'h1FFFFF)));
      write_csr(CSR_LOW_THR, 28'($urandom_range(200)));
      write_csr(CSR_HIGH_THR, 28'($urandom_range(100, 400)));
      write_csr(CSR_BASE_RTT, 28'($urandom_range(255)));
      write_csr(CSR_MIN_WIN, 28'($urandom_range(28'h3FFFFF)));
      write_csr(CSR_INC_COUNT, 28'($urandom_range(255)));
   endtask

   initial begin
      gain_q = 9'd205; beta_q = 9'd77; step_q = 21'd16384;
      low_thr_q = 16'd60; high_thr_q = 16'd150; base_rtt_q = 16'd50;
      min_win_q = 28'd65536; inc_count_q = 8'd1;
      last_rtt_q = LastRttReset; gradient = '0; cwnd = WinReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: regions, wrap, saturation, extremes of the fields
      queue_ack(32'd1000, 32'd10);
      queue_ack(32'd2000, 32'd100);
      queue_ack(32'd3000, 32'd140);
      queue_ack(32'd4000, 32'd90);
      queue_ack(32'd5000, 32'd300);
      queue_ack(32'hFFFF_FFFF, 32'd0);
      queue_ack(32'd0, 32'hFFFF_FFFF);
      queue_ack(32'd5, 32'd6);
      queue_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_ack(32'h0001_0000, 32'h0000_FFFF);
      drain_updates();
      // extremes: gain and beta above one, zero base, full count, big steps
      write_csr(CSR_EWMA_GAIN, 28'h1FF);
      write_csr(CSR_DECREASE, 28'h1FF);
      write_csr(CSR_ADD_STEP, 28'h1FFFFF);
      write_csr(CSR_LOW_THR, 28'd0);
      write_csr(CSR_HIGH_THR, 28'hFFFF);
      write_csr(CSR_BASE_RTT, 28'd0);
      write_csr(CSR_MIN_WIN, 28'd0);
      write_csr(CSR_INC_COUNT, 28'd255);
      for (int i = 0; i < 6; i++) queue_ack(32'd100 * i, 32'd40 - 32'd7 * i);
      queue_ack(32'd7, 32'd65535);
      drain_updates();
      write_csr(CSR_INC_COUNT, 28'd0);
      write_csr(CSR_MIN_WIN, 28'hFFFFFFF);
      write_csr(CSR_EWMA_GAIN, 28'd0);
      queue_ack(32'd50, 32'd20);
      queue_ack(32'd50, 32'd30);
      drain_updates();
      write_csr(CSR_MIN_WIN, 28'd65536);
      write_csr(CSR_LOW_THR, 28'hFFFF);
      queue_ack(32'd99, 32'd5);
      drain_updates();

      // random phases: idle, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         if (phase != 0) randomize_csrs();
         queue_random_acks(166, high_thr_q);
         drain_updates();
      end

      $display("covered %0d window updates: low %0d, high %0d, grad add %0d, grad dec %0d",
               updates_seen, region_hits[0], region_hits[1], region_hits[2],
               region_hits[3]);
      if (mismatches == 0 && update_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
